// File: rtl/b2d_pkg.sv
// ----------------------------------------------------------------------------
// b2d_pkg: shared types and constants of the binary to decimal ASCII unit
// Holds the request and response structs, the stage record that walks down
// the conversion chain, and the digit width constants.
// ----------------------------------------------------------------------------
package b2d_pkg;

    // Field widths
    localparam int VALUE_W    = 32;
    localparam int MIN_W      = 4;
    localparam int CHAR_W     = 6;

    // Number of decimal digits formed and kept
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int POS_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int CMP_W      = (CNT_W > MIN_W) ? CNT_W : MIN_W;

    // ASCII code of the character '0'
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef t_digit [NUM_DIGITS-1:0] t_bcd;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [MIN_W-1:0]   min_digits;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_out;

    // Record handed from cell to cell down the conversion chain
    typedef struct packed {
        logic               valid;
        t_bcd               bcd;
        logic [VALUE_W-1:0] bits;
        logic [MIN_W-1:0]   min_digits;
    } t_stage;

endpackage

// File: rtl/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit: 32-bit unsigned binary to decimal ASCII
// A row of shift-and-add-3 cells turns the value into BCD digits, one bit a
// cell; a serializer then sends the digits as characters, leading zeros
// dropped down to the requested minimum count.
//
//   Channel  Direction  Handshake          Payload
//   request  in         i_valid / o_ready  i_req: value, min_digits
//   result   out        o_valid / i_ready  o_rsp: digit_char, last
//
// A request passes through 32 cells, one per cycle while the row advances,
// then reaches the serializer. It emits one to ten characters, one per cycle
// while i_ready is high; each request yields max(significant digits, clamped
// min_digits) characters.
// Reset clears all valid flags and the serializer; no clearing pass.
// The whole cell row holds while the serializer has a number in hand and
// advances only in the cycle its final character is taken, so a stalled
// result also holds the request side.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  b2d_pkg::t_in  i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output b2d_pkg::t_out o_rsp
);

    b2d_pkg::t_stage w_stage [0:b2d_pkg::VALUE_W];
    logic            w_en;

    // Feed a new request into the head of the row
    always_comb begin
        w_stage[0].valid      = i_valid;
        w_stage[0].bcd        = '0;
        w_stage[0].bits       = i_req.value;
        w_stage[0].min_digits = i_req.min_digits;
    end

    assign o_ready = w_en;

    // Chain one cell per input bit
    for (genvar g = 0; g < b2d_pkg::VALUE_W; g++) begin : g_cell
        b2d_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    b2d_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (w_stage[b2d_pkg::VALUE_W]),
        .o_load_ready (w_en),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_rsp        (o_rsp)
    );

endmodule

// File: rtl/b2d_cell.sv
// ----------------------------------------------------------------------------
// b2d_cell: one shift-and-add-3 step of the conversion chain
// Corrects every BCD digit of five or more by adding three, then shifts the
// top bit of the remaining binary word into the units digit.
// ----------------------------------------------------------------------------
module b2d_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  b2d_pkg::t_stage i_stage,
    output b2d_pkg::t_stage o_stage
);

    b2d_pkg::t_bcd   w_corr;
    b2d_pkg::t_stage r_stage;
    b2d_pkg::t_stage n_stage;

    // Add three to each digit of five or more
    always_comb begin
        for (int k = 0; k < b2d_pkg::NUM_DIGITS; k++) begin
            if (i_stage.bcd[k] >= b2d_pkg::DIGIT_W'(5)) begin
                w_corr[k] = i_stage.bcd[k] + b2d_pkg::DIGIT_W'(3);
            end else begin
                w_corr[k] = i_stage.bcd[k];
            end
        end
    end

    // Shift the next binary bit into the digit row
    always_comb begin
        n_stage.valid      = i_stage.valid;
        n_stage.bcd        = b2d_pkg::t_bcd'({w_corr, i_stage.bits[b2d_pkg::VALUE_W-1]});
        n_stage.bits       = {i_stage.bits[b2d_pkg::VALUE_W-2:0], 1'b0};
        n_stage.min_digits = i_stage.min_digits;
    end

    // Hold the stage while the chain is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.bcd        <= n_stage.bcd;
            r_stage.bits       <= n_stage.bits;
            r_stage.min_digits <= n_stage.min_digits;
        end
    end

    assign o_stage = r_stage;

endmodule

// File: rtl/b2d_emit.sv
// ----------------------------------------------------------------------------
// b2d_emit: digit serializer
// Takes the finished digit row, sets the character count from the highest
// nonzero digit and clamped minimum, then sends that many, top digit first.
// ----------------------------------------------------------------------------
module b2d_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  b2d_pkg::t_stage i_stage,
    output logic            o_load_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output b2d_pkg::t_out   o_rsp
);

    logic                       r_busy;
    logic                       n_busy;
    logic [b2d_pkg::POS_W-1:0]  r_pos;
    logic [b2d_pkg::POS_W-1:0]  n_pos;
    b2d_pkg::t_bcd              r_digits;
    logic [b2d_pkg::CNT_W-1:0]  w_sig;
    logic [b2d_pkg::CNT_W-1:0]  w_min;
    logic [b2d_pkg::CNT_W-1:0]  w_count;
    logic [b2d_pkg::CMP_W-1:0]  w_min_ext;
    logic                       w_done;
    b2d_pkg::t_digit            w_digit;

    // Find the number of significant digits
    always_comb begin
        w_sig = '0;
        for (int k = 0; k < b2d_pkg::NUM_DIGITS; k++) begin
            if (i_stage.bcd[k] != '0) begin
                w_sig = b2d_pkg::CNT_W'(k + 1);
            end
        end
    end

    // Clamp the requested minimum into one to the digit count
    always_comb begin
        w_min_ext = b2d_pkg::CMP_W'(i_stage.min_digits);
        if (w_min_ext == '0) begin
            w_min = b2d_pkg::CNT_W'(1);
        end else if (w_min_ext > b2d_pkg::CMP_W'(b2d_pkg::NUM_DIGITS)) begin
            w_min = b2d_pkg::CNT_W'(b2d_pkg::NUM_DIGITS);
        end else begin
            w_min = b2d_pkg::CNT_W'(w_min_ext);
        end
        w_count = (w_sig > w_min) ? w_sig : w_min;
    end

    // Free for a new row when idle or when the final character leaves
    assign w_done       = r_busy && i_ready && (r_pos == '0);
    assign o_load_ready = !r_busy || w_done;

    // Advance the character position
    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        if (o_load_ready) begin
            n_busy = i_stage.valid;
            n_pos  = b2d_pkg::POS_W'(w_count - b2d_pkg::CNT_W'(1));
        end else if (r_busy && i_ready) begin
            n_pos  = r_pos - b2d_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
        if (o_load_ready) begin
            r_digits <= i_stage.bcd;
        end
    end

    // Drive the current character
    assign w_digit          = r_digits[r_pos];
    assign o_valid          = r_busy;
    assign o_rsp.digit_char = b2d_pkg::ASCII_ZERO + b2d_pkg::CHAR_W'(w_digit);
    assign o_rsp.last       = (r_pos == '0);

endmodule

// File: tb/binary_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit_tb: self-checking bench of the decimal unit
// Sends requests of a 32-bit value and a minimum digit count, and predicts the
// ASCII digit characters of each one. Every character that comes out is
// checked in order against the prediction. A short table of corner requests
// runs first, then random requests. Both sides pause at random.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit_tb;

    localparam int CLK_HALF    = 5;
    localparam int N_DIRECTED  = 22;
    localparam int N_RANDOM    = 408;
    localparam int DRAIN_CYC   = 64;
    localparam int STALL_LIMIT = 4000;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_ready = 1'b0;
    b2d_pkg::t_in  i_req   = '0;
    logic          o_ready;
    logic          o_valid;
    b2d_pkg::t_out o_rsp;

    // Characters still owed by the unit, oldest first
    b2d_pkg::t_out due_chars [$];
    int   errors     = 0;
    int   char_index = 0;
    bit   send_calm  = 1'b0;
    bit   rsp_calm   = 1'b0;

    // Corner requests; a non-empty text is the known answer
    b2d_pkg::t_in dir_req [N_DIRECTED] = '{
        '{value: 32'd0,          min_digits: 4'd1},
        '{value: 32'd0,          min_digits: 4'd0},
        '{value: 32'd0,          min_digits: 4'd10},
        '{value: 32'd0,          min_digits: 4'd15},
        '{value: 32'hFFFFFFFF,   min_digits: 4'd1},
        '{value: 32'hFFFFFFFF,   min_digits: 4'd15},
        '{value: 32'hFFFFFFFF,   min_digits: 4'd0},
        '{value: 32'd9,          min_digits: 4'd1},
        '{value: 32'd10,         min_digits: 4'd1},
        '{value: 32'd1000000000, min_digits: 4'd1},
        '{value: 32'd999999999,  min_digits: 4'd10},
        '{value: 32'd999999999,  min_digits: 4'd1},
        '{value: 32'd7,          min_digits: 4'd3},
        '{value: 32'd12345,      min_digits: 4'd11},
        '{value: 32'h80000000,   min_digits: 4'd1},
        '{value: 32'd100,        min_digits: 4'd2},
        '{value: 32'h55555555,   min_digits: 4'd4},
        '{value: 32'hAAAAAAAA,   min_digits: 4'd8},
        '{value: 32'd1,          min_digits: 4'd14},
        '{value: 32'd4294967290, min_digits: 4'd12},
        '{value: 32'd100000,     min_digits: 4'd6},
        '{value: 32'd99999,      min_digits: 4'd5}
    };
    string dir_text [N_DIRECTED] = '{
        "0", "0", "0000000000", "0000000000",
        "4294967295", "4294967295", "4294967295",
        "9", "10", "1000000000", "0999999999", "999999999",
        "007", "0000012345", "2147483648",
        "", "", "", "", "", "", ""
    };

    binary_to_decimal_ascii_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    // Free-running clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Predict the characters of one request
    function automatic void format_decimal(b2d_pkg::t_in req);
        b2d_pkg::t_digit digs [b2d_pkg::NUM_DIGITS];
        logic [63:0]     v;
        int              sig;
        int              floor_cnt;
        int              count;
        int              pos;
        b2d_pkg::t_out   ch;
        v   = 64'(req.value);
        sig = 0;
        for (int k = 0; k < b2d_pkg::NUM_DIGITS; k++) begin
            digs[k] = b2d_pkg::t_digit'(v % 10);
            v = v / 10;
            if (digs[k] != '0) begin
                sig = k + 1;
            end
        end
        floor_cnt = int'(req.min_digits);
        if (floor_cnt < 1) begin
            floor_cnt = 1;
        end
        if (floor_cnt > b2d_pkg::NUM_DIGITS) begin
            floor_cnt = b2d_pkg::NUM_DIGITS;
        end
        count = (sig > floor_cnt) ? sig : floor_cnt;
        for (int k = 0; k < count; k++) begin
            pos           = count - 1 - k;
            ch.digit_char = b2d_pkg::ASCII_ZERO + b2d_pkg::CHAR_W'(digs[pos]);
            ch.last       = (pos == 0);
            due_chars.push_back(ch);
        end
    endfunction

    // Queue a known answer given as text
    function automatic void queue_text(string text);
        b2d_pkg::t_out ch;
        for (int k = 0; k < text.len(); k++) begin
            ch.digit_char = b2d_pkg::CHAR_W'(text[k]);
            ch.last       = (k == text.len() - 1);
            due_chars.push_back(ch);
        end
    endfunction

    // Pause length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Values spread over all digit counts, powers of ten and all-nines
    function automatic logic [31:0] random_value();
        logic [63:0] p10;
        int          p;
        logic [31:0] v;
        p10 = 64'd1;
        p   = $urandom_range(0, 9);
        for (int k = 0; k < p; k++) begin
            p10 = p10 * 10;
        end
        case ($urandom_range(0, 5))
            1: begin
                v = $urandom_range(0, 99);
            end
            2: begin
                v = 32'(p10 + 64'($urandom_range(0, 4)) - 64'd2);
            end
            3: begin
                v = $urandom >> $urandom_range(0, 31);
            end
            4: begin
                v = 32'(p10 - 64'd1);
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    function automatic logic [b2d_pkg::MIN_W-1:0] random_min();
        if ($urandom_range(0, 4) == 0) begin
            return b2d_pkg::MIN_W'($urandom_range(0, 15));
        end
        return b2d_pkg::MIN_W'($urandom_range(1, b2d_pkg::NUM_DIGITS));
    endfunction

    // Send one request and queue its characters once it is taken
    task automatic send_request(input b2d_pkg::t_in req, input string text);
        int gap;
        gap = send_calm ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_req   <= b2d_pkg::t_in'({$urandom, b2d_pkg::MIN_W'($urandom_range(0, 15))});
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (!o_ready);
        if (text.len() != 0) begin
            queue_text(text);
        end else begin
            format_decimal(req);
        end
    endtask

    // Check one character against the oldest one owed
    task automatic check_char(input b2d_pkg::t_out got);
        b2d_pkg::t_out want;
        if (due_chars.size() == 0) begin
            $display("%0t: char %0d unexpected: expected none, actual char %0d last %0b",
                     $time, char_index, got.digit_char, got.last);
            errors++;
        end else begin
            want = due_chars.pop_front();
            if (got.digit_char !== want.digit_char) begin
                $display("%0t: char %0d digit_char mismatch: expected %0d actual %0d",
                         $time, char_index, want.digit_char, got.digit_char);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: char %0d last mismatch: expected %0b actual %0b",
                         $time, char_index, want.last, got.last);
                errors++;
            end
        end
        char_index++;
    endtask

    // Result side: take characters, stall at random
    initial begin
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc        = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                check_char(o_rsp);
            end
            if (cyc % 64 == 0) begin
                rsp_calm = ($urandom_range(0, 3) == 0);
            end
            cyc++;
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                stall_left = rsp_calm ? 0 : idle_len();
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int idle_cyc;
        idle_cyc = 0;
        while (idle_cyc < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cyc = 0;
            end else begin
                idle_cyc++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("** binary_to_decimal_ascii_unit: FAILED **");
        $finish;
    end

    // Request side and end of run
    initial begin
        b2d_pkg::t_in req;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the corner table
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(dir_req[i], dir_text[i]);
        end

        // Random requests, with calm stretches and one full drain midway
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 40 == 0) begin
                send_calm = ($urandom_range(0, 3) == 0);
            end
            if (i == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (due_chars.size() != 0);
            end
            req.value      = random_value();
            req.min_digits = random_min();
            send_request(req, "");
        end
        i_valid <= 1'b0;

        // Drain, then give stray characters time to show up
        while (due_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (errors == 0) begin
            $display("** binary_to_decimal_ascii_unit: PASSED **");
        end else begin
            $display("** binary_to_decimal_ascii_unit: FAILED **");
        end
        $finish;
    end

endmodule
